### rtl/swpm_pkg.sv
// Shared types and codes for the stack with pop-minimum.
package swpm_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_PEEK   = 2'd2,
		MODE_POPMIN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage

### rtl/swpm_in_if.sv
// Request channel: operation code and value to push.
interface swpm_in_if;
	import swpm_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	data_t push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

### rtl/swpm_out_if.sv
// Result channel: value, status and empty flag.
interface swpm_out_if;
	import swpm_pkg::*;

	logic    valid;
	logic    ready;
	data_t   result_value;
	status_t status;
	logic    now_empty;

	modport source (output valid, output result_value, output status, output now_empty,
		input ready);
	modport sink   (input valid, input result_value, input status, input now_empty,
		output ready);
endinterface

### rtl/stack_with_pop_minimum.sv
// Bounded stack of signed 32-bit values with push, pop, peek and pop-minimum.
//
// Requests arrive on in_ch (mode, push_value); each yields one transaction on
// out_ch (result_value, status, now_empty). Both use valid/ready handshakes.
// A push, or any request on an empty stack, has its result registered at the
// accepting edge; pop and peek first go through one registered memory read
// (S_READ); pop-minimum first runs the S_SCAN and S_SHIFT passes.
// Pop-minimum walks the store once to find the first smallest entry, then
// moves every entry above it down by one. Both passes run through the single
// read port of the element memory, one entry per cycle, with one comparator
// and one index counter shared between them.
// One request is in progress at a time: no new request is taken while one is
// being worked on. in_ch is ready again once the result has been taken, or
// in the cycle it is taken. A stalled out_ch holds the result and keeps in_ch
// blocked until it drains. Reset empties the stack at once; memory contents
// are not cleared, and stale contents are never used before being written.
module stack_with_pop_minimum #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	swpm_in_if.sink           in_ch,
	swpm_out_if.source        out_ch
);
	import swpm_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_SHIFT = 4'b1000
	} state_t;

	state_t          state_q;
	mode_t           mode_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   best_idx_q;
	data_t           best_q;
	data_t           rd_data_q;
	data_t           mem [DEPTH];

	data_t           res_value_q;
	status_t         res_status_q;
	logic            res_empty_q;
	logic            out_valid_q;

	logic            accept;
	logic            out_take;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	data_t           wr_data;
	logic            take_new;
	logic [AW-1:0]   best_idx_next;
	logic            scan_last;
	logic            shift_more;
	logic [CW-1:0]   count_dec;

	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_take    = out_valid_q && out_ch.ready;

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_value = res_value_q;
	assign out_ch.status       = res_status_q;
	assign out_ch.now_empty    = res_empty_q;

	assign count_dec = count_q - CW'(1);

	// Shared compare: first entry seeds the search, strict less keeps the lowest index
	assign take_new      = (idx_q == '0) || (rd_data_q < best_q);
	assign best_idx_next = take_new ? idx_q : best_idx_q;
	assign scan_last     = (CW'(idx_q) == count_dec);
	assign shift_more    = ((CW'(idx_q) + CW'(1)) < count_q);

	always_comb begin
		rd_addr = idx_q + AW'(1);
		case (state_q)
			S_IDLE: begin
				if (in_ch.mode == MODE_POPMIN)
					rd_addr = '0;
				else
					rd_addr = count_dec[AW-1:0];
			end
			S_SCAN: begin
				if (scan_last)
					rd_addr = best_idx_next + AW'(1);
				else
					rd_addr = idx_q + AW'(1);
			end
			S_SHIFT: rd_addr = idx_q + AW'(2);
			default: rd_addr = idx_q + AW'(1);
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data_q;
		if (accept && in_ch.mode == MODE_PUSH && count_q < CW'(DEPTH)) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = in_ch.push_value;
		end else if (state_q == S_SHIFT && shift_more) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_take)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_ch.mode == MODE_PUSH) begin
							if (count_q < CW'(DEPTH))
								count_q <= count_q + CW'(1);
							out_valid_q <= 1'b1;
						end else if (count_q == '0) begin
							out_valid_q <= 1'b1;
						end else if (in_ch.mode == MODE_POPMIN) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (mode_q == MODE_POP)
						count_q <= count_dec;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_last)
						state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (!shift_more) begin
						count_q     <= count_dec;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: index, best candidate and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q <= in_ch.mode;
					idx_q  <= '0;
					if (in_ch.mode == MODE_PUSH) begin
						res_value_q  <= '0;
						res_status_q <= (count_q < CW'(DEPTH)) ? ST_OK : ST_FULL;
						res_empty_q  <= 1'b0;
					end else if (count_q == '0) begin
						res_value_q  <= '0;
						res_status_q <= ST_EMPTY;
						res_empty_q  <= 1'b1;
					end
				end
			end
			S_READ: begin
				res_value_q  <= rd_data_q;
				res_status_q <= ST_OK;
				res_empty_q  <= (mode_q == MODE_POP) && (count_dec == '0);
			end
			S_SCAN: begin
				if (take_new)
					best_q <= rd_data_q;
				best_idx_q <= best_idx_next;
				// hand the counter over to the shift pass at the chosen slot
				if (scan_last)
					idx_q <= best_idx_next;
				else
					idx_q <= idx_q + AW'(1);
			end
			S_SHIFT: begin
				idx_q <= idx_q + AW'(1);
				if (!shift_more) begin
					res_value_q  <= best_q;
					res_status_q <= ST_OK;
					res_empty_q  <= (count_dec == '0);
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.mode == MODE_PUSH && count_q < CW'(DEPTH))
		|=> (count_q == $past(count_q) + CW'(1)))
		else $error("accepted push did not grow the stack");

	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SHIFT || state_q == S_READ) |-> (count_q != '0))
		else $error("memory pass on an empty stack");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_status_q == ST_EMPTY) |-> res_empty_q)
		else $error("empty status without empty flag");

endmodule

### tb/testbench.sv
// Self-checking testbench for the bounded stack with push, pop, peek and pop-minimum.
`timescale 1ns / 100ps

module testbench;
	import swpm_pkg::*;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned SETTLE_CYCLES = 2 * STACK_DEPTH + 8;
	localparam int unsigned RANDOM_REQUESTS = 1000;

	typedef struct {
		mode_t op;
		data_t value;
		int    gap;
		bit    hold;
	} request_t;

	typedef struct {
		data_t   value;
		status_t status;
		logic    now_empty;
	} stack_result_t;

	logic clk = 1'b0;
	logic arst_n;

	swpm_in_if  req ();
	swpm_out_if rsp ();

	stack_with_pop_minimum #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req),
		.out_ch (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t      pending_q[$];
	stack_result_t due_results[$];
	int unsigned   mismatches = 0;

	// Shadow copy of the stack contents
	data_t       shadow_stack[STACK_DEPTH];
	int unsigned shadow_fill = 0;

	function automatic stack_result_t stack_outcome(mode_t op, data_t value);
		stack_result_t r;
		int unsigned best;
		r.value = '0;
		r.status = ST_OK;
		if (op == MODE_PUSH) begin
			if (shadow_fill == STACK_DEPTH)
				r.status = ST_FULL;
			else begin
				shadow_stack[shadow_fill] = value;
				shadow_fill++;
			end
		end else if (shadow_fill == 0) begin
			r.status = ST_EMPTY;
		end else if (op == MODE_POP) begin
			shadow_fill--;
			r.value = shadow_stack[shadow_fill];
		end else if (op == MODE_PEEK) begin
			r.value = shadow_stack[shadow_fill - 1];
		end else begin
			// first smallest entry from the bottom, then close the gap
			best = 0;
			for (int unsigned i = 1; i < shadow_fill; i++)
				if (shadow_stack[i] < shadow_stack[best])
					best = i;
			r.value = shadow_stack[best];
			for (int unsigned i = best; i + 1 < shadow_fill; i++)
				shadow_stack[i] = shadow_stack[i + 1];
			shadow_fill--;
		end
		r.now_empty = (shadow_fill == 0);
		return r;
	endfunction

	// Alternate runs of random waits with runs of no waits at all
	function automatic int draw_gap(inout int run_left, inout bit calm);
		if (run_left == 0) begin
			run_left = $urandom_range(20, 60);
			calm = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic data_t pick_value();
		case ($urandom_range(0, 3))
			1: return data_t'(int'($urandom_range(0, 8)) - 4);
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return data_t'($urandom);
		endcase
	endfunction

	int sender_run = 0;
	bit sender_calm = 1'b0;

	task automatic enqueue(mode_t op, data_t value, bit hold);
		request_t item;
		item.op = op;
		item.value = value;
		item.gap = draw_gap(sender_run, sender_calm);
		item.hold = hold;
		pending_q.push_back(item);
	endtask

	// Request driver
	request_t cur;
	bit       staged = 1'b0;
	bit       presenting = 1'b0;
	int       wait_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.mode <= MODE_PUSH;
			req.push_value <= '0;
			staged = 1'b0;
			presenting = 1'b0;
		end else begin
			if (presenting && req.ready) begin
				due_results.push_back(stack_outcome(req.mode, req.push_value));
				presenting = 1'b0;
			end
			if (!presenting) begin
				// hold a flagged request back until every result has drained
				if (!staged && pending_q.size() > 0
						&& (!pending_q[0].hold || due_results.size() == 0)) begin
					cur = pending_q.pop_front();
					staged = 1'b1;
					wait_left = cur.gap;
				end
				if (staged && wait_left == 0) begin
					staged = 1'b0;
					presenting = 1'b1;
					req.mode <= cur.op;
					req.push_value <= cur.value;
				end else if (staged) begin
					wait_left--;
				end
			end
			req.valid <= presenting;
		end
	end

	// Result monitor
	int stall_left = 0;
	int sink_run = 0;
	bit sink_calm = 1'b0;

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall_left = draw_gap(sink_run, sink_calm);
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual value %0d",
						$time, rsp.result_value);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if ($isunknown({rsp.result_value, rsp.status, rsp.now_empty})) begin
						$display("%0t: unknown bits, expected %h/%0d/%0b, actual %h/%0d/%0b",
							$time, want.value, want.status, want.now_empty,
							rsp.result_value, rsp.status, rsp.now_empty);
						mismatches++;
					end else begin
						check_field("result_value", want.value, rsp.result_value);
						check_field("status", want.status, rsp.status);
						check_field("now_empty", want.now_empty, rsp.now_empty);
					end
				end
				stall_left = draw_gap(sink_run, sink_calm);
			end
			rsp.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin
		int  phase_left;
		bit  filling;
		mode_t op;

		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = MODE_PUSH;
		req.push_value = '0;
		rsp.ready = 1'b0;

		// empty stack on every reading operation
		enqueue(MODE_POP, 32'sd11, 1'b0);
		enqueue(MODE_PEEK, 32'sd12, 1'b0);
		enqueue(MODE_POPMIN, 32'sd13, 1'b0);
		// all entries at the largest value: bottom one goes
		enqueue(MODE_PUSH, 32'sh7fff_ffff, 1'b0);
		enqueue(MODE_PUSH, 32'sh7fff_ffff, 1'b0);
		enqueue(MODE_POPMIN, '0, 1'b0);
		enqueue(MODE_POP, '0, 1'b0);
		// fill to the brim with extremes and two equal minima
		enqueue(MODE_PUSH, 32'sh5555_5555, 1'b0);
		enqueue(MODE_PUSH, 32'shaaaa_aaaa, 1'b0);
		enqueue(MODE_PUSH, 32'sh8000_0000, 1'b0);
		enqueue(MODE_PUSH, '1, 1'b0);
		enqueue(MODE_PUSH, '0, 1'b0);
		enqueue(MODE_PUSH, 32'sd1, 1'b0);
		enqueue(MODE_PUSH, 32'sh8000_0000, 1'b0);
		enqueue(MODE_PUSH, 32'sh7fff_ffff, 1'b0);
		for (int i = 0; i < 8; i++)
			enqueue(MODE_PUSH, pick_value(), 1'b0);
		enqueue(MODE_PUSH, 32'sh1234_5678, 1'b0);
		enqueue(MODE_POPMIN, '0, 1'b0);
		enqueue(MODE_PEEK, '1, 1'b0);

		phase_left = 0;
		filling = 1'b0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// swing between filling and draining so both ends are reached
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 40);
				filling = !filling;
			end
			phase_left--;
			if ($urandom_range(0, 99) < (filling ? 75 : 25))
				op = MODE_PUSH;
			else begin
				case ($urandom_range(0, 2))
					0: op = MODE_POP;
					1: op = MODE_PEEK;
					default: op = MODE_POPMIN;
				endcase
			end
			enqueue(op, pick_value(), (n % 150) == 0);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || staged || presenting)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
